[rtl/merge_sorter_macros.svh]
// ---------------------------------------------------------------------------
// merge_sorter assertion macros
// shared property wrappers for the merge_sorter checkers; each one samples on
// the rising edge of clk and is disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// same-cycle implication
`define MS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ms_pkg.sv]
// ---------------------------------------------------------------------------
// ms_pkg
// types shared by the merge sorter controller, datapath and top level
// ---------------------------------------------------------------------------
package ms_pkg;

  // one input element of a batch
  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_item_t;

  // one sorted result
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_batch;
  } out_item_t;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_INIT  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_EMIT  = 4'b1000
  } ms_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // input transfer this cycle
    logic pass_init;  // set up the first run pair of a pass
    logic merge;      // merge one element
    logic emit;       // move sorted elements to the output register
  } ms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;       // current run width still below the batch size
    logic pass_end;   // last element of the pass written this cycle
    logic emit_done;  // last element of the batch loaded for output
  } ms_stat_t;

endpackage

[rtl/ms_ctrl.sv]
// ---------------------------------------------------------------------------
// ms_ctrl
// sequencer for the merge sorter: load, per-pass setup, merge, emit
// ---------------------------------------------------------------------------
module ms_ctrl
  import ms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_is_last,
  input  ms_stat_t stat,
  output ms_cmd_t  cmd,
  output logic     in_stall
);

  ms_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && in_is_last) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        state_nxt = stat.more ? ST_MERGE : ST_EMIT;
      end
      ST_MERGE: begin
        if (stat.pass_end) state_nxt = ST_INIT;
      end
      ST_EMIT: begin
        if (stat.emit_done) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd.load      = (state_r == ST_LOAD) && in_valid && rst_n;
    cmd.pass_init = (state_r == ST_INIT);
    cmd.merge     = (state_r == ST_MERGE);
    cmd.emit      = (state_r == ST_EMIT);
  end

  // inputs only taken while loading
  assign in_stall = (state_r != ST_LOAD) || !rst_n;

endmodule

[rtl/ms_dpath.sv]
// ---------------------------------------------------------------------------
// ms_dpath
// ping-pong buffers, merge pointers, run width and output register
// ---------------------------------------------------------------------------
module ms_dpath
  import ms_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ms_cmd_t   cmd,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output ms_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 2;

  // buffers
  logic [31:0] mem_a [CAPACITY];
  logic [31:0] mem_b [CAPACITY];

  // batch size, run width, source buffer select (0: a is source)
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   w_r, w_nxt;
  logic          sel_r, sel_nxt;

  // merge pointers
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] mid_r, mid_nxt, hi_r, hi_nxt;

  // registered read data of both buffers
  logic [31:0] rd_al_r, rd_ar_r, rd_bl_r, rd_br_r;
  logic signed [31:0] head_l, head_r, wr_data;

  logic          take_left, pair_end, pass_end, load_wr;
  logic          out_free, load_out, emit_done;
  logic [CW-1:0] lo, mid_c, hi_c;
  logic [SW-1:0] sum_mid, sum_hi;

  logic      out_v_r, out_v_nxt;
  out_item_t out_data_r;

  // heads of the left and right runs
  assign head_l = sel_r ? rd_bl_r : rd_al_r;
  assign head_r = sel_r ? rd_br_r : rd_ar_r;

  // stable pick: left wins on equal values
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || (head_l <= head_r));
  assign wr_data   = take_left ? head_l : head_r;
  assign pair_end  = (k_r + 1'b1) == hi_r;
  assign pass_end  = cmd.merge && pair_end && (hi_r == count_r);
  assign load_wr   = cmd.load && (count_r < CW'(CAPACITY));

  // bounds of the next run pair, clipped to the batch size
  assign lo      = cmd.pass_init ? '0 : hi_r;
  assign sum_mid = SW'(lo) + SW'(w_r);
  assign sum_hi  = SW'(lo) + (SW'(w_r) << 1);
  assign mid_c   = (sum_mid > SW'(count_r)) ? count_r : sum_mid[CW-1:0];
  assign hi_c    = (sum_hi > SW'(count_r)) ? count_r : sum_hi[CW-1:0];

  // output register handoff
  assign out_free  = !out_v_r || !out_stall;
  assign load_out  = cmd.emit && out_free;
  assign emit_done = load_out && ((i_r + 1'b1) == count_r);

  // status
  always_comb begin
    stat.more      = w_r < {1'b0, count_r};
    stat.pass_end  = pass_end;
    stat.emit_done = emit_done;
  end

  // pointer and control next values
  always_comb begin
    count_nxt = count_r;
    w_nxt     = w_r;
    sel_nxt   = sel_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    if (load_wr) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pass_init) begin
      i_nxt   = '0;
      j_nxt   = mid_c;
      mid_nxt = mid_c;
      hi_nxt  = hi_c;
      k_nxt   = '0;
    end
    if (cmd.merge) begin
      k_nxt = k_r + 1'b1;
      if (pass_end) begin
        sel_nxt = ~sel_r;
        w_nxt   = w_r << 1;
      end else if (pair_end) begin
        i_nxt   = hi_r;
        j_nxt   = mid_c;
        mid_nxt = mid_c;
        hi_nxt  = hi_c;
      end else if (take_left) begin
        i_nxt = i_r + 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
    if (load_out) begin
      i_nxt = i_r + 1'b1;
    end
    if (emit_done) begin
      count_nxt = '0;
      w_nxt     = (CW + 1)'(1);
      sel_nxt   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      w_r     <= (CW + 1)'(1);
      sel_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      w_r     <= w_nxt;
      sel_r   <= sel_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // pointer registers
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
  end

  // buffer a: loaded from input, merge target on odd passes
  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem_a[count_r[AW-1:0]] <= in_data.value;
    end else if (cmd.merge && sel_r) begin
      mem_a[k_r[AW-1:0]] <= wr_data;
    end
    rd_al_r <= mem_a[i_nxt[AW-1:0]];
    rd_ar_r <= mem_a[j_nxt[AW-1:0]];
  end

  // buffer b: merge target on even passes
  always_ff @(posedge clk) begin
    if (cmd.merge && !sel_r) begin
      mem_b[k_r[AW-1:0]] <= wr_data;
    end
    rd_bl_r <= mem_b[i_nxt[AW-1:0]];
    rd_br_r <= mem_b[j_nxt[AW-1:0]];
  end

  // output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.sorted_value <= head_l;
      out_data_r.end_of_batch <= (i_r + 1'b1) == count_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

[rtl/merge_sorter.sv]
// ---------------------------------------------------------------------------
// merge_sorter
// batch sorter for signed 32-bit values, stable bottom-up merge sort
// ---------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one element per transfer; is_last closes
//   the batch. up to CAPACITY elements are kept, later ones are dropped until
//   the closing element arrives (which is also dropped when the batch is full).
//   loading takes one transfer per cycle.
//   after the closing transfer in_stall stays high while the batch is sorted:
//   each pass has a setup step followed by the merge of its elements, with
//   ceil(log2 n) passes, then one more setup step; merge speed is set by the
//   single write port of the target buffer, one element per cycle.
//   the results then follow at one per cycle while out_stall is low.
//   out_valid/out_stall/out_data deliver the results in ascending order, equal
//   values in arrival order, end_of_batch set on the last one.
//   a stalled result holds in the output register; emission pauses with it.
//   the next batch is taken as soon as the last result sits in that register.
//   rst_n (synchronous) empties the batch and drops any pending result.
// ---------------------------------------------------------------------------
module merge_sorter
  import ms_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ms_cmd_t  cmd;
  ms_stat_t stat;

  // sequencer
  ms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_data.is_last),
    .stat       (stat),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  // buffers and merge datapath
  ms_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/ms_checker.sv]
// ---------------------------------------------------------------------------
// ms_checker
// port-level checks on the merge sorter, bound to every merge_sorter
// ---------------------------------------------------------------------------
`include "merge_sorter_macros.svh"

module ms_checker
  import ms_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic out_held;
  logic in_closing;
  logic out_mid_batch;

  // handshake terms used by the checks
  assign out_held      = out_valid && out_stall;
  assign in_closing    = in_valid && !in_stall && in_data.is_last;
  assign out_mid_batch = out_valid && !out_data.end_of_batch;

  // a stalled result holds
  `MS_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_data), "result changed under stall")

  // closing transfer starts the sort, no input taken next cycle
  `MS_ASSERT_NXT(a_sort_start, in_closing, in_stall, "input taken right after batch close")

  // a pending result inside the batch means emission is still running
  `MS_ASSERT_IMP(a_emit_busy, out_mid_batch, in_stall, "input taken during emission")

endmodule

bind merge_sorter ms_checker u_ms_checker (.*);
